/* src/sfd_pkg.sv */
// Shared types and constants for the servo frame deframer.
`default_nettype none
package sfd_pkg;

  // Default number of 16-bit channel values in one frame.
  localparam int CHANNELS_DEFAULT = 8;

  // Entries in the queue between the parser and the clamp stage.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port widths.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_FIRST  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_SECOND = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PULSE     = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PULSE     = 4'd3;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_HIGH,
    PH_LOW
  } phase_t;

  // One assembled channel value waiting for the clamp stage.
  typedef struct packed {
    logic [2:0]  channel_index;
    logic [15:0] raw;
    logic        frame_last;
  } chan_item_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

/* src/sfd_front.sv */
// Byte parser: header hunt, channel byte assembly and queue push.
`default_nettype none
module sfd_front #(
  parameter int CHANNELS = sfd_pkg::CHANNELS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,
  input  wire logic [7:0]         header_first,
  input  wire logic [7:0]         header_second,
  input  wire sfd_pkg::q_stat_t   q_stat,
  output logic                    q_push,
  output sfd_pkg::chan_item_t     q_item
);
  import sfd_pkg::*;

  localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHANNELS - 1);

  phase_t           phase;
  phase_t           phase_next;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       high_hold;
  logic [CNT_W+2:0] cnt_ext;
  logic             accept;
  logic             is_last;

  // Every byte waits for queue room, so the queue can never overflow.
  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign is_last  = (cnt == CNT_LAST);
  assign cnt_ext  = {3'b000, cnt};

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HUNT1: begin
          if (s_tdata == header_first) phase_next = PH_HUNT2;
        end
        PH_HUNT2: begin
          // A second-header match wins over the re-arm on the first header.
          if (s_tdata == header_second) begin
            phase_next = PH_HIGH;
          end else if (s_tdata != header_first) begin
            phase_next = PH_HUNT1;
          end
        end
        PH_HIGH: phase_next = PH_LOW;
        PH_LOW:  phase_next = is_last ? PH_HUNT1 : PH_HIGH;
        default: phase_next = PH_HUNT1;
      endcase
    end
  end

  always_comb begin
    q_push              = accept && (phase == PH_LOW);
    q_item.channel_index = cnt_ext[2:0];
    q_item.raw          = {high_hold, s_tdata};
    q_item.frame_last   = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT1;
      cnt       <= '0;
      high_hold <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        if (phase == PH_HUNT2 && s_tdata == header_second) begin
          cnt <= '0;
        end else if (phase == PH_HIGH) begin
          high_hold <= s_tdata;
        end else if (phase == PH_LOW) begin
          cnt <= is_last ? '0 : cnt + CNT_W'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_LAST)
    else $error("channel counter ran past the last channel");

  a_push_only_low: assert property (@(posedge clk) disable iff (rst)
    q_push |=> (phase == PH_HIGH || phase == PH_HUNT1))
    else $error("parser did not leave the low-byte phase after a push");
`endif

endmodule
`default_nettype wire

/* src/sfd_queue.sv */
// Short queue between the parser and the clamp stage.
`default_nettype none
module sfd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire sfd_pkg::chan_item_t push_item,
  input  wire logic                pop,
  output sfd_pkg::chan_item_t      head_item,
  output sfd_pkg::q_stat_t         stat
);
  import sfd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W:0] COUNT_FULL = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  chan_item_t       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  assign stat.full  = (count == COUNT_FULL);
  assign stat.empty = (count == '0);
  assign head_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_LAST) ? '0 : wptr + PTR_W'(1);
      if (pop)  rptr <= (rptr == PTR_LAST) ? '0 : rptr + PTR_W'(1);
      if (push && !pop)      count <= count + (PTR_W + 1)'(1);
      else if (pop && !push) count <= count - (PTR_W + 1)'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> !pop)
    else $error("pop from an empty queue");
`endif

endmodule
`default_nettype wire

/* src/sfd_back.sv */
// Clamp stage and output register of the deframer.
`default_nettype none
module sfd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sfd_pkg::chan_item_t head_item,
  input  wire sfd_pkg::q_stat_t    q_stat,
  output logic                     q_pop,
  input  wire logic [15:0]         min_pulse_ticks,
  input  wire logic [15:0]         max_pulse_ticks,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [23:0]              m_tdata,
  output logic [1:0]               m_tuser,
  output logic                     m_tlast
);
  import sfd_pkg::*;

  logic        below;
  logic        above;
  logic [15:0] clamped;
  logic [2:0]  out_index;
  logic [15:0] out_ticks;

  // The output register takes a new item whenever it is empty or being drained.
  assign q_pop = !q_stat.empty && (!m_tvalid || m_tready);

  // With min above max, the upper bound takes priority.
  always_comb begin
    below = (head_item.raw < min_pulse_ticks);
    above = (head_item.raw > max_pulse_ticks);
    if (above)      clamped = max_pulse_ticks;
    else if (below) clamped = min_pulse_ticks;
    else            clamped = head_item.raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_index <= head_item.channel_index;
      out_ticks <= clamped;
      m_tuser   <= {above, below};
      m_tlast   <= head_item.frame_last;
    end
  end

  assign m_tdata = {5'b00000, out_ticks, out_index};

`ifndef SYNTHESIS
  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_tvalid)
    else $error("output register empty after a pop");
`endif

endmodule
`default_nettype wire

/* src/servo_frame_deframer.sv */
// Top level of the servo frame deframer: configuration registers and datapath.
//
//   Port group   Dir  Width  Contents
//   s_axis       in   8      rx_byte
//   m_axis       out  24/2/1 tdata: channel_index, pulse_ticks; tuser: clamp flags;
//                            tlast: frame_last
//   cfg          in   4/16   register index, write data
//
// One byte is taken per cycle while the queue has room. Each result passes
// through the queue and then the output register, from which up to one result
// per cycle drains. A two-entry queue separates the parser from the clamp
// stage, so a stalled output only holds back input once the queue is full.
// Reset is synchronous and returns the parser to the header hunt.
`default_nettype none
module servo_frame_deframer #(
  parameter int CHANNELS = sfd_pkg::CHANNELS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,   // [7:0] rx_byte
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [23:0]                         m_tdata,   // [2:0] channel_index, [18:3] pulse_ticks
  output logic [1:0]                          m_tuser,   // [0] clamped_low, [1] clamped_high
  output logic                                m_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [sfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [sfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sfd_pkg::*;

  logic [7:0]  header_first;
  logic [7:0]  header_second;
  logic [15:0] min_pulse_ticks;
  logic [15:0] max_pulse_ticks;

  q_stat_t    q_stat;
  logic       q_push;
  logic       q_pop;
  chan_item_t push_item;
  chan_item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first    <= '0;
      header_second   <= '0;
      min_pulse_ticks <= '0;
      max_pulse_ticks <= '1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HEADER_FIRST:  header_first    <= cfg_wdata[7:0];
        REG_HEADER_SECOND: header_second   <= cfg_wdata[7:0];
        REG_MIN_PULSE:     min_pulse_ticks <= cfg_wdata[15:0];
        REG_MAX_PULSE:     max_pulse_ticks <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  sfd_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .header_first (header_first),
    .header_second(header_second),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  sfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .head_item(head_item),
    .stat     (q_stat)
  );

  sfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_item      (head_item),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .min_pulse_ticks(min_pulse_ticks),
    .max_pulse_ticks(max_pulse_ticks),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast)
  );

endmodule
`default_nettype wire

/* tb/servo_frame_deframer_test.sv */
// Self-checking testbench for the servo frame deframer: byte stream in, clamped channels out.
`default_nettype none
module servo_frame_deframer_test;
  import sfd_pkg::*;

  localparam int FRAME_CHANNELS = CHANNELS_DEFAULT;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [2:0]  channel_index;
    logic [15:0] pulse_ticks;
    logic        clamped_low;
    logic        clamped_high;
    logic        frame_last;
  } chan_result_t;

  // Tracks the parser state on its own and holds the channel values still owed.
  class deframe_scoreboard;
    logic [7:0]   hdr_first;
    logic [7:0]   hdr_second;
    logic [15:0]  min_ticks;
    logic [15:0]  max_ticks;
    phase_t       phase;
    int unsigned  chan_count;
    logic [7:0]   high_hold;
    chan_result_t owed[$];
    int           mismatches;
    int           bytes_in;
    int           values_seen;
    int           frames_seen;
    int           low_clamps;
    int           high_clamps;

    function new();
      hdr_first   = 8'h00;
      hdr_second  = 8'h00;
      min_ticks   = 16'h0000;
      max_ticks   = 16'hFFFF;
      phase       = PH_HUNT1;
      chan_count  = 0;
      high_hold   = 8'h00;
      mismatches  = 0;
      bytes_in    = 0;
      values_seen = 0;
      frames_seen = 0;
      low_clamps  = 0;
      high_clamps = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_HEADER_FIRST:  hdr_first  = val[7:0];
        REG_HEADER_SECOND: hdr_second = val[7:0];
        REG_MIN_PULSE:     min_ticks  = val;
        REG_MAX_PULSE:     max_ticks  = val;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      chan_result_t r;
      logic [15:0]  raw;
      bytes_in++;
      case (phase)
        PH_HUNT1: begin
          if (b == hdr_first) phase = PH_HUNT2;
        end
        PH_HUNT2: begin
          // A second-header match wins over re-arming on the first header byte.
          if (b == hdr_second) begin
            phase = PH_HIGH;
            chan_count = 0;
          end else if (b != hdr_first) begin
            phase = PH_HUNT1;
          end
        end
        PH_HIGH: begin
          high_hold = b;
          phase = PH_LOW;
        end
        default: begin
          raw = {high_hold, b};
          r.clamped_low  = (raw < min_ticks);
          r.clamped_high = (raw > max_ticks);
          if (r.clamped_high) r.pulse_ticks = max_ticks;
          else if (r.clamped_low) r.pulse_ticks = min_ticks;
          else r.pulse_ticks = raw;
          r.channel_index = chan_count[2:0];
          r.frame_last = (chan_count >= FRAME_CHANNELS - 1);
          owed.push_back(r);
          if (r.frame_last) begin
            phase = PH_HUNT1;
            chan_count = 0;
          end else begin
            phase = PH_HIGH;
            chan_count++;
          end
        end
      endcase
    endfunction

    function void check_result(logic [23:0] tdata, logic [1:0] tuser, logic tlast);
      chan_result_t got;
      chan_result_t want;
      got.channel_index = tdata[2:0];
      got.pulse_ticks   = tdata[18:3];
      got.clamped_low   = tuser[0];
      got.clamped_high  = tuser[1];
      got.frame_last    = tlast;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected item ch=%0d ticks=%0d lo=%0b hi=%0b last=%0b",
                   got.channel_index, got.pulse_ticks, got.clamped_low,
                   got.clamped_high, got.frame_last);
        return;
      end
      want = owed.pop_front();
      values_seen++;
      if (want.frame_last) frames_seen++;
      if (want.clamped_low) low_clamps++;
      if (want.clamped_high) high_clamps++;
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: mismatch expected ch=%0d ticks=%0d lo=%0b hi=%0b last=%0b, ",
                    "got ch=%0d ticks=%0d lo=%0b hi=%0b last=%0b"},
                   want.channel_index, want.pulse_ticks, want.clamped_low,
                   want.clamped_high, want.frame_last, got.channel_index,
                   got.pulse_ticks, got.clamped_low, got.clamped_high, got.frame_last);
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  deframe_scoreboard sb = new();
  int burst_left = 0;
  int bytes_sent = 0;
  int settings_used = 0;
  int cycles = 0;
  int rx_left = 0;
  int rx_mode = 0;

  servo_frame_deframer #(.CHANNELS(FRAME_CHANNELS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: switches between always ready, coin flips, a fixed stall pattern and long stalls.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (rx_left[1:0] == 2'd0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_channel(input logic [15:0] v);
    send_byte(v[15:8]);
    send_byte(v[7:0]);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers; junk lands in the unused upper bits and in an unused index.
  task automatic apply_setting(input logic [7:0] hf, input logic [7:0] hs,
                               input logic [15:0] mn, input logic [15:0] mx);
    logic [CFG_ADDR_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    logic [CFG_ADDR_W-1:0] spare;
    logic [CFG_DATA_W-1:0] junk;
    idx[0] = REG_HEADER_FIRST;
    idx[1] = REG_HEADER_SECOND;
    idx[2] = REG_MIN_PULSE;
    idx[3] = REG_MAX_PULSE;
    val[0] = {8'($urandom_range(0, 255)), hf};
    val[1] = {8'($urandom_range(0, 255)), hs};
    val[2] = mn;
    val[3] = mx;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    spare = CFG_ADDR_W'(REG_MAX_PULSE + 1 + $urandom_range(0, 11));
    junk  = CFG_DATA_W'($urandom_range(0, 65535));
    cfg_addr  <= spare;
    cfg_wdata <= junk;
    @(posedge clk);
    sb.write_reg(spare, junk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return sb.min_ticks;
      3: return sb.min_ticks - 16'd1;
      4: return sb.max_ticks;
      5: return sb.max_ticks + 16'd1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly well-formed frames with random content, mixed with noise and broken headers.
  task automatic send_random_frames(input int quota);
    int start;
    int kind;
    int nch;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      kind = $urandom_range(0, 11);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
      nch = FRAME_CHANNELS;
      case (kind)
        0: begin
          send_byte(sb.hdr_first);
          send_byte(8'($urandom_range(0, 255)));
          nch = 0;
        end
        1: begin
          send_byte(sb.hdr_first);
          send_byte(sb.hdr_first);
          send_byte(sb.hdr_second);
        end
        2: begin
          send_byte(sb.hdr_first);
          send_byte(sb.hdr_second);
          nch = $urandom_range(1, FRAME_CHANNELS - 1);
        end
        default: begin
          send_byte(sb.hdr_first);
          send_byte(sb.hdr_second);
        end
      endcase
      for (int i = 0; i < nch; i++) send_channel(pick_value());
    end
  endtask

  initial begin
    logic [15:0] a;
    logic [15:0] b;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'h00;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: sliding hunt, re-arm on a repeated first header, then range edges.
    apply_setting(8'hA5, 8'h5A, 16'd1000, 16'd2000);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h33);
    send_byte(8'hA5);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_channel(16'h0000);
    send_channel(16'hFFFF);
    send_channel(16'd999);
    send_channel(16'd1000);
    send_channel(16'd2000);
    send_channel(16'd2001);
    send_channel(16'h0500);
    send_channel(16'h8000);
    wait_drain();

    // Equal header bytes with the minimum above the maximum.
    apply_setting(8'h7E, 8'h7E, 16'd3000, 16'd1000);
    send_byte(8'h7E);
    send_byte(8'h7E);
    send_channel(16'd2048);
    send_channel(16'd256);
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      a = 16'($urandom_range(0, 65535));
      b = 16'($urandom_range(0, 65535));
      case (p)
        0: apply_setting(8'h00, 8'h00, 16'h0000, 16'hFFFF);
        1: apply_setting(8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)),
                         (a < b) ? a : b, (a < b) ? b : a);
        2: begin
          a[7:0] = 8'($urandom_range(0, 255));
          apply_setting(a[7:0], a[7:0], b, b);
        end
        3: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         (a > b) ? a : b, (a > b) ? b : a);
        4: apply_setting(8'hFF, 8'h00, 16'h0000, 16'h0000);
        5: apply_setting(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
        default: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               a, b);
      endcase
      send_random_frames(170);
      wait_drain();
    end

    $display("Ran %0d bytes under %0d register settings: %0d channel values, %0d full frames,",
             sb.bytes_in, settings_used, sb.values_seen, sb.frames_seen);
    $display("%0d raised to the minimum, %0d lowered to the maximum, %0d mismatches.",
             sb.low_clamps, sb.high_clamps, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
src/sfd_pkg.sv
src/sfd_front.sv
src/sfd_queue.sv
src/sfd_back.sv
src/servo_frame_deframer.sv
tb/servo_frame_deframer_test.sv
